// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cbd_pkg.sv -----
package cbd_pkg;

   // Width of a parsed chunk size and of the decoded byte counter.
   localparam int SIZE_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int TOTAL_BITS = 32;

   // Characters that the size line and trailer look for.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // Status codes reported with every result beat.
   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic                  payload_valid;
      logic [7:0]            payload_byte;
      logic [1:0]            status;
      logic [TOTAL_BITS-1:0] decoded_total;
   } cbd_result_type;

   // Classifies one byte as a hexadecimal digit and gives its value.
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.is_hex = 1'b0;
      h.value  = 4'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CHAR_ZERO);
      end else if (b >= CHAR_LO_A && b <= CHAR_LO_F) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CHAR_LO_A + 8'd10);
      end else if (b >= CHAR_UP_A && b <= CHAR_UP_F) begin
         h.is_hex = 1'b1;
         h.value  = 4'(b - CHAR_UP_A + 8'd10);
      end
      return h;
   endfunction

   // White space that may lead a size line.
   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_LF) ||
             (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
   endfunction

endpackage

// ----- hw/rtl/cbd_core.sv -----
`include "assert_macros.svh"

module cbd_core
   import cbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     in_byte,
   output cbd_result_type result
);

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_NUM    = 3'd1,
      PH_TAIL   = 3'd2,
      PH_LINECR = 3'd3,
      PH_DATA   = 3'd4,
      PH_TRAIL  = 3'd5,
      PH_FINAL  = 3'd6,
      PH_ERR    = 3'd7
   } phase_type;

   // Meanings of the two-bit step register, which depend on the phase.
   localparam logic [1:0] PREFIX_NONE   = 2'd0;
   localparam logic [1:0] PREFIX_ZERO   = 2'd1;
   localparam logic [1:0] PREFIX_X      = 2'd2;
   localparam logic [1:0] PREFIX_DIGITS = 2'd3;
   localparam logic [1:0] TRAIL_WANT_CR = 2'd0;
   localparam logic [1:0] TRAIL_WANT_LF = 2'd1;
   localparam logic [1:0] FINAL_FIRST   = 2'd0;
   localparam logic [1:0] FINAL_SECOND  = 2'd1;

   phase_type              phase_ff, phase_in, size_phase;
   logic [SIZE_BITS-1:0]   chunk_ff, chunk_in;
   logic [1:0]             prefix_ff, prefix_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   size_en;
   logic                   pvalid;
   logic                   done;
   logic                   overflow;
   hex_type                hex;

   assign hex      = hex_decode(in_byte);
   assign overflow = (chunk_ff[SIZE_BITS-1 -: 4] != 4'd0);

   // Next state for one byte; size-line bytes share one decoder.
   always_comb begin
      phase_in   = phase_ff;
      chunk_in   = chunk_ff;
      prefix_in  = prefix_ff;
      count_in   = count_ff;
      pvalid     = 1'b0;
      done       = 1'b0;
      size_en    = 1'b0;
      size_phase = phase_ff;

      case (phase_ff)
         PH_LEAD, PH_NUM, PH_TAIL: begin
            size_en = 1'b1;
         end
         PH_LINECR: begin
            if (in_byte == CHAR_LF) begin
               if (prefix_ff == PREFIX_NONE) begin
                  phase_in = PH_ERR;
               end else if (chunk_ff == '0) begin
                  phase_in  = PH_FINAL;
                  prefix_in = FINAL_FIRST;
               end else begin
                  phase_in  = PH_DATA;
                  prefix_in = TRAIL_WANT_CR;
               end
            end else begin
               // A lone CR falls back into the line and this byte is parsed there.
               size_en    = 1'b1;
               size_phase = (prefix_ff == PREFIX_NONE) ? PH_LEAD : PH_TAIL;
               phase_in   = size_phase;
            end
         end
         PH_DATA: begin
            pvalid   = 1'b1;
            chunk_in = chunk_ff - 1'b1;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            if (chunk_ff == SIZE_BITS'(1)) begin
               phase_in  = PH_TRAIL;
               prefix_in = TRAIL_WANT_CR;
            end
         end
         PH_TRAIL: begin
            if (prefix_ff == TRAIL_WANT_CR) begin
               if (in_byte == CHAR_CR) begin
                  prefix_in = TRAIL_WANT_LF;
               end else begin
                  phase_in = PH_ERR;
               end
            end else if (in_byte == CHAR_LF) begin
               phase_in  = PH_LEAD;
               prefix_in = PREFIX_NONE;
               chunk_in  = '0;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_FINAL: begin
            if (prefix_ff == FINAL_FIRST) begin
               prefix_in = FINAL_SECOND;
            end else begin
               done      = 1'b1;
               phase_in  = PH_LEAD;
               prefix_in = PREFIX_NONE;
               chunk_in  = '0;
            end
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase

      // Size-line byte: CR, lead, digits, or ignored tail text.
      if (size_en) begin
         if (in_byte == CHAR_CR) begin
            phase_in = PH_LINECR;
         end else begin
            case (size_phase)
               PH_LEAD: begin
                  if (is_space(in_byte)) begin
                     phase_in = PH_LEAD;
                  end else if (in_byte == CHAR_ZERO) begin
                     phase_in  = PH_NUM;
                     prefix_in = PREFIX_ZERO;
                     chunk_in  = '0;
                  end else if (hex.is_hex) begin
                     phase_in  = PH_NUM;
                     prefix_in = PREFIX_DIGITS;
                     chunk_in  = SIZE_BITS'(hex.value);
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM: begin
                  if (prefix_ff == PREFIX_ZERO &&
                      (in_byte == CHAR_LO_X || in_byte == CHAR_UP_X)) begin
                     prefix_in = PREFIX_X;
                  end else if (hex.is_hex) begin
                     if (overflow) begin
                        phase_in = PH_ERR;
                     end else begin
                        chunk_in  = {chunk_ff[SIZE_BITS-5:0], hex.value};
                        prefix_in = PREFIX_DIGITS;
                     end
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
               default: begin
                  // Text after the digits is skipped.
               end
            endcase
         end
      end
   end

   // Result fields for this byte; an error overrides the payload and status fields.
   always_comb begin
      result.decoded_total = TOTAL_BITS'(count_in);
      if (phase_in == PH_ERR) begin
         result.payload_valid = 1'b0;
         result.payload_byte  = 8'd0;
         result.status        = STATUS_ERROR;
      end else begin
         result.payload_valid = pvalid;
         result.payload_byte  = pvalid ? in_byte : 8'd0;
         result.status        = done ? STATUS_DONE : STATUS_BUSY;
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         chunk_ff  <= '0;
         prefix_ff <= PREFIX_NONE;
         count_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         chunk_ff  <= chunk_in;
         prefix_ff <= prefix_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEXT(a_error_sticky, clock, reset, phase_ff == PH_ERR, phase_ff == PH_ERR, "error state left")
   `ASSERT_NEXT(a_count_hold, clock, reset, !step_en, count_ff == $past(count_ff), "count moved while idle")
   `ASSERT_IMPLY(a_payload_phase, clock, reset, step_en && result.payload_valid, phase_ff == PH_DATA, "payload outside data phase")

endmodule

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// A byte accepted on req is held in the input register, then parsed into the result
// register, which presents its beat on rsp.
// Throughput: one byte per cycle while rsp is ready; a stalled result beat holds while
// one more byte waits in the input register; the per-byte parser update sets the cycle.
// Reset (synchronous, active high) empties both registers and returns the parser to the
// start of a size line with a zero byte count; errors stay until the next reset.
`include "assert_macros.svh"

module http_chunked_body_decoder
   import cbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [39:8] decoded_total
   output logic [2:0]  rsp_tuser    // [0] payload_valid, [2:1] status
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   cbd_result_type out_result_ff;
   cbd_result_type core_result;
   logic           advance;
   logic           step;
   logic           req_beat;

   // The output register frees when empty or when its beat is taken.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   cbd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .in_byte (in_byte_ff),
      .result  (core_result)
   );

   // Input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_beat) begin
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.decoded_total, out_result_ff.payload_byte};
   assign rsp_tuser  = {out_result_ff.status, out_result_ff.payload_valid};

   `ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "waiting byte lost")
   `ASSERT_NEXT(a_step_shows, clock, reset, step, rsp_tvalid, "processed byte gave no beat")
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !in_valid_ff, req_tready, "empty input not ready")

endmodule
